### hw/rtl/etiu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etiu_pkg
// Shared types and constants of the eased tween interpolator unit.
// ----------------------------------------------------------------------------
package etiu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELAPSED_W     = 24;
  localparam int VAL_W         = 16;
  localparam int MS_W          = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int PERIOD_W      = MS_W + 1;

  localparam logic [MS_W-1:0] DURATION_RESET = MS_W'(1000);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION     = 3'd0,
    CFG_DELAY        = 3'd1,
    CFG_REPEATS      = 3'd2,
    CFG_OUT_AND_BACK = 3'd3,
    CFG_CURVE_OUT    = 3'd4,
    CFG_CURVE_BACK   = 3'd5
  } cfg_idx_t;

  // Easing curve codes.
  typedef enum logic [1:0] {
    CURVE_LIN         = 2'd0,
    CURVE_OUT_QUAD    = 2'd1,
    CURVE_IN_QUAD     = 2'd2,
    CURVE_IN_OUT_QUAD = 2'd3
  } curve_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [MS_W-1:0]     dur;     // zero already mapped to one
    logic [MS_W-1:0]     dly;
    logic [PERIOD_W-1:0] period;  // dur + dly, registered
    logic                repeats;
    logic                oab;
    curve_t              curve_out;
    curve_t              curve_back;
  } cfg_t;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    logic signed [VAL_W-1:0] start_value;
    logic signed [VAL_W-1:0] end_value;
    logic                    started;
    logic                    done;
  } side_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    side_t                side;
  } mod_side_t;

  typedef struct packed {
    logic  sat;
    side_t side;
  } frac_side_t;

endpackage

### hw/rtl/etiu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etiu_if
// Valid/ready channels for query items and result items.
// ----------------------------------------------------------------------------
interface etiu_in_if;
  import etiu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ELAPSED_W-1:0]    elapsed_ms;
  logic signed [VAL_W-1:0] start_value;
  logic signed [VAL_W-1:0] end_value;
  logic [MS_W-1:0]         done_margin_ms;

  modport source (output valid, elapsed_ms, start_value, end_value, done_margin_ms,
                  input ready);
  modport sink (input valid, elapsed_ms, start_value, end_value, done_margin_ms,
                output ready);
endinterface

interface etiu_out_if;
  import etiu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    started;
  logic                    done_res;

  modport source (output valid, value, started, done_res, input ready);
  modport sink (input valid, value, started, done_res, output ready);
endinterface

### hw/rtl/etiu_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etiu_cfg
// Configuration registers with the derived duration and period values.
// ----------------------------------------------------------------------------
module etiu_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            we,
  input  logic [etiu_pkg::CFG_IDX_W-1:0]  idx,
  input  logic [etiu_pkg::CFG_DATA_W-1:0] data,
  output etiu_pkg::cfg_t                  cfg
);
  import etiu_pkg::*;

  logic [MS_W-1:0]     dur_r;
  logic [MS_W-1:0]     dly_r;
  logic                repeats_r;
  logic                oab_r;
  curve_t              curve_out_r;
  curve_t              curve_back_r;
  logic [PERIOD_W-1:0] period_r;
  logic [MS_W-1:0]     dur_eff;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r        <= DURATION_RESET;
      dly_r        <= '0;
      repeats_r    <= 1'b0;
      oab_r        <= 1'b0;
      curve_out_r  <= CURVE_LIN;
      curve_back_r <= CURVE_LIN;
    end else if (we) begin
      unique case (idx)
        CFG_DURATION:     dur_r        <= data[MS_W-1:0];
        CFG_DELAY:        dly_r        <= data[MS_W-1:0];
        CFG_REPEATS:      repeats_r    <= data[0];
        CFG_OUT_AND_BACK: oab_r        <= data[0];
        CFG_CURVE_OUT:    curve_out_r  <= curve_t'(data[1:0]);
        CFG_CURVE_BACK:   curve_back_r <= curve_t'(data[1:0]);
        default: ;
      endcase
    end
  end

  // A zero duration behaves as one millisecond.
  assign dur_eff = (dur_r == '0) ? MS_W'(1) : dur_r;

  // The repeat period is registered; it is used only past the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_W'(DURATION_RESET);
    end else begin
      period_r <= PERIOD_W'(dur_eff) + PERIOD_W'(dly_r);
    end
  end

  assign cfg.dur        = dur_eff;
  assign cfg.dly        = dly_r;
  assign cfg.period     = period_r;
  assign cfg.repeats    = repeats_r;
  assign cfg.oab        = oab_r;
  assign cfg.curve_out  = curve_out_r;
  assign cfg.curve_back = curve_back_r;

endmodule

### hw/rtl/etiu_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etiu_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module etiu_div_pipe #(
  parameter int N_BITS = 16,  // dividend bits, one stage each
  parameter int D_W    = 16,  // divisor and remainder width
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [N_BITS-1:0] dividend,
  input  logic [D_W-1:0]    rem_init,  // must be below divisor
  input  logic [D_W-1:0]    divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_v,
  output logic [N_BITS-1:0] quot,
  output logic [D_W-1:0]    rem,
  output logic [SIDE_W-1:0] side_out
);

  logic              v_r    [N_BITS];
  logic [D_W-1:0]    rem_r  [N_BITS];
  logic [N_BITS-1:0] dvd_r  [N_BITS];
  logic [N_BITS-1:0] quot_r [N_BITS];
  logic [SIDE_W-1:0] side_r [N_BITS];

  genvar i;
  for (i = 0; i < N_BITS; i++) begin : g_stage
    logic              v_in;
    logic [D_W-1:0]    rem_in;
    logic [N_BITS-1:0] dvd_in;
    logic [N_BITS-1:0] quot_in;
    logic [SIDE_W-1:0] s_in;
    logic [D_W:0]      trial;
    logic              fits;
    logic [D_W-1:0]    rem_nxt;

    if (i == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = rem_init;
      assign dvd_in  = dividend;
      assign quot_in = '0;
      assign s_in    = side_in;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign dvd_in  = dvd_r[i-1];
      assign quot_in = quot_r[i-1];
      assign s_in    = side_r[i-1];
    end

    // Shift in the next dividend bit and subtract the divisor if it fits.
    assign trial   = {rem_in, dvd_in[N_BITS-1]};
    assign fits    = trial >= {1'b0, divisor};
    assign rem_nxt = fits ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        dvd_r[i]  <= dvd_in << 1;
        quot_r[i] <= {quot_in[N_BITS-2:0], fits};
        side_r[i] <= s_in;
      end
    end
  end

  assign out_v    = v_r[N_BITS-1];
  assign quot     = quot_r[N_BITS-1];
  assign rem      = rem_r[N_BITS-1];
  assign side_out = side_r[N_BITS-1];

endmodule

### hw/rtl/etiu_ease.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etiu_ease
// Out-and-back folding, easing curve, scaling by the value span and rounding.
// ----------------------------------------------------------------------------
module etiu_ease #(
  parameter int FRACTION_BITS = etiu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  etiu_pkg::cfg_t                  cfg,
  input  logic                            in_v,
  input  logic [FRACTION_BITS:0]          t,
  input  etiu_pkg::side_t                 side_in,
  output logic                            out_v,
  output logic signed [etiu_pkg::VAL_W-1:0] value,
  output logic                            started,
  output logic                            done
);
  import etiu_pkg::*;

  localparam int TW  = FRACTION_BITS + 1;
  localparam int PW  = 2 * TW + 1;
  localparam int DW  = VAL_W + 1;
  localparam int SPW = TW + 1 + DW;
  localparam logic [TW-1:0] ONE  = TW'(1) << FRACTION_BITS;
  localparam logic [TW-1:0] HALF = ONE >> 1;

  // Stage A: fold progress for out-and-back and pick the curve.
  logic                 v_a_r;
  logic [TW-1:0]        a_r;
  curve_t               crv_a_r;
  logic signed [DW-1:0] diff_a_r;
  side_t                side_a_r;
  logic [TW-1:0]        a_nxt;
  curve_t               crv_nxt;

  always_comb begin
    if (!cfg.oab) begin
      a_nxt   = t;
      crv_nxt = cfg.curve_out;
    end else if (t < HALF) begin
      a_nxt   = t << 1;
      crv_nxt = cfg.curve_out;
    end else begin
      a_nxt   = TW'(ONE - t) << 1;
      crv_nxt = cfg.curve_back;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      crv_a_r  <= crv_nxt;
      diff_a_r <= DW'(side_in.end_value) - DW'(side_in.start_value);
      side_a_r <= side_in;
    end
  end

  // Stage B: one square-type product for the quadratic curves.
  logic                 v_b_r;
  logic [PW-1:0]        prod_b_r;
  logic                 lin_b_r;
  logic                 inv_b_r;
  logic [TW-1:0]        a_b_r;
  logic signed [DW-1:0] diff_b_r;
  side_t                side_b_r;
  logic [TW-1:0]        mx;
  logic [TW:0]          my;
  logic                 lin_nxt;
  logic                 inv_nxt;
  logic [TW-1:0]        u;

  always_comb begin
    u       = ONE - a_r;
    mx      = a_r;
    my      = '0;
    lin_nxt = 1'b0;
    inv_nxt = 1'b0;
    unique case (crv_a_r)
      CURVE_LIN: begin
        lin_nxt = 1'b1;
      end
      CURVE_OUT_QUAD: begin
        my = {ONE, 1'b0} - {1'b0, a_r};
      end
      CURVE_IN_QUAD: begin
        my = {1'b0, a_r};
      end
      CURVE_IN_OUT_QUAD: begin
        if (a_r < HALF) begin
          my = {a_r, 1'b0};
        end else begin
          mx      = u;
          my      = {u, 1'b0};
          inv_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (en) begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_b_r <= PW'(mx) * PW'(my);
      lin_b_r  <= lin_nxt;
      inv_b_r  <= inv_nxt;
      a_b_r    <= a_r;
      diff_b_r <= diff_a_r;
      side_b_r <= side_a_r;
    end
  end

  // Stage C: scale the product back to the fraction format.
  logic                 v_c_r;
  logic [TW-1:0]        e_c_r;
  logic signed [DW-1:0] diff_c_r;
  side_t                side_c_r;
  logic [TW-1:0]        scaled;
  logic [TW-1:0]        e_nxt;

  assign scaled = TW'(prod_b_r >> FRACTION_BITS);

  always_comb begin
    if (lin_b_r) begin
      e_nxt = a_b_r;
    end else if (inv_b_r) begin
      e_nxt = ONE - scaled;
    end else begin
      e_nxt = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (en) begin
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_c_r    <= e_nxt;
      diff_c_r <= diff_b_r;
      side_c_r <= side_b_r;
    end
  end

  // Stage D: eased fraction times the value span.
  logic                  v_d_r;
  logic signed [SPW-1:0] span_d_r;
  side_t                 side_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
    end else if (en) begin
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span_d_r <= $signed({1'b0, e_c_r}) * diff_c_r;
      side_d_r <= side_c_r;
    end
  end

  // Stage E: round half up (floor of the shifted sum) and add the start.
  logic                    v_e_r;
  logic signed [VAL_W-1:0] val_e_r;
  logic                    started_e_r;
  logic                    done_e_r;
  logic signed [SPW-1:0]   rnd;
  logic signed [SPW-1:0]   q;

  assign rnd = span_d_r + $signed({{(SPW - TW){1'b0}}, HALF});
  assign q   = rnd >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (en) begin
      v_e_r <= v_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_e_r     <= side_d_r.start_value + $signed(q[VAL_W-1:0]);
      started_e_r <= side_d_r.started;
      done_e_r    <= side_d_r.done;
    end
  end

  assign out_v   = v_e_r;
  assign value   = val_e_r;
  assign started = started_e_r;
  assign done    = done_e_r;

endmodule

### hw/rtl/eased_tween_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_tween_interpolator_unit
// Eased tween value, started and done flags; one query per unstalled cycle.
// ----------------------------------------------------------------------------
// The unit takes one query item per clock cycle while the skid register is
// empty and returns one result item per query, in order. The pipeline is
// one input stage, a 24-stage bit-per-stage divider that folds the elapsed
// time into the repeat period, one stage that removes the delay and clamps,
// a FRACTION_BITS-stage divider that forms the progress fraction, and five
// stages of easing and scaling. A result skid register catches the item that
// leaves the pipeline while the sink stalls; from the next cycle the pipeline
// and in_if.ready hold until that item has been taken, so ready never
// depends combinationally on out_if.ready. Configuration is written through
// cfg_we, cfg_idx and cfg_data and should only change while no item is in
// flight.
module eased_tween_interpolator_unit #(
  parameter int FRACTION_BITS = etiu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  etiu_in_if.sink                         in_if,
  etiu_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [etiu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [etiu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import etiu_pkg::*;

  localparam int TW = FRACTION_BITS + 1;
  localparam logic [TW-1:0] ONE = TW'(1) << FRACTION_BITS;
  localparam int LHS_W = ELAPSED_W + 2;

  cfg_t cfg;
  logic en;
  logic skid_v_r;

  etiu_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // The whole pipeline advances while the skid register is empty.
  assign en           = !skid_v_r;
  assign in_if.ready  = en;

  // Input stage: started and done flags.
  logic             fv_r;
  mod_side_t        fside_r;
  logic [LHS_W-1:0] lhs;
  logic             done_nxt;

  assign lhs = LHS_W'(in_if.elapsed_ms) - LHS_W'(in_if.done_margin_ms) - LHS_W'(cfg.dly);
  assign done_nxt = !cfg.repeats && ($signed(lhs) > $signed(LHS_W'(cfg.dur)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fside_r.elapsed           <= in_if.elapsed_ms;
      fside_r.side.start_value  <= in_if.start_value;
      fside_r.side.end_value    <= in_if.end_value;
      fside_r.side.started      <= in_if.elapsed_ms >= ELAPSED_W'(cfg.dly);
      fside_r.side.done         <= done_nxt;
    end
  end

  // Elapsed time modulo the repeat period.
  logic                mv;
  logic [PERIOD_W-1:0] mrem;
  mod_side_t           mside;

  etiu_div_pipe #(
    .N_BITS (ELAPSED_W),
    .D_W    (PERIOD_W),
    .SIDE_W ($bits(mod_side_t))
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (fv_r),
    .dividend (fside_r.elapsed),
    .rem_init ('0),
    .divisor  (cfg.period),
    .side_in  (fside_r),
    .out_v    (mv),
    .quot     (),
    .rem      (mrem),
    .side_out (mside)
  );

  // Remove the delay and clamp progress past the end of a single pass.
  logic                 cv_r;
  logic [MS_W-1:0]      crem_r;
  frac_side_t           cside_r;
  logic [ELAPSED_W-1:0] d;
  logic [ELAPSED_W-1:0] num;
  logic                 past_dly;
  logic                 sat_nxt;

  assign d        = cfg.repeats ? ELAPSED_W'(mrem) : mside.elapsed;
  assign past_dly = d >= ELAPSED_W'(cfg.dly);
  assign num      = d - ELAPSED_W'(cfg.dly);
  assign sat_nxt  = !cfg.repeats && past_dly && (num >= ELAPSED_W'(cfg.dur));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else if (en) begin
      cv_r <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crem_r       <= (past_dly && !sat_nxt) ? num[MS_W-1:0] : '0;
      cside_r.sat  <= sat_nxt;
      cside_r.side <= mside.side;
    end
  end

  // Progress fraction: (time into the pass << FRACTION_BITS) / duration.
  logic                     pv;
  logic [FRACTION_BITS-1:0] pq;
  frac_side_t               pside;
  logic [TW-1:0]            t;

  etiu_div_pipe #(
    .N_BITS (FRACTION_BITS),
    .D_W    (MS_W),
    .SIDE_W ($bits(frac_side_t))
  ) u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (cv_r),
    .dividend ('0),
    .rem_init (crem_r),
    .divisor  (cfg.dur),
    .side_in  (cside_r),
    .out_v    (pv),
    .quot     (pq),
    .rem      (),
    .side_out (pside)
  );

  assign t = pside.sat ? ONE : {1'b0, pq};

  // Easing and scaling.
  logic                    ev;
  logic signed [VAL_W-1:0] eval;
  logic                    estarted;
  logic                    edone;

  etiu_ease #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ease (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg),
    .in_v    (pv),
    .t       (t),
    .side_in (pside.side),
    .out_v   (ev),
    .value   (eval),
    .started (estarted),
    .done    (edone)
  );

  // Skid register holds one result item while the sink stalls.
  logic signed [VAL_W-1:0] skid_val_r;
  logic                    skid_started_r;
  logic                    skid_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_if.ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (ev && !out_if.ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_val_r     <= eval;
      skid_started_r <= estarted;
      skid_done_r    <= edone;
    end
  end

  assign out_if.valid    = skid_v_r || ev;
  assign out_if.value    = skid_v_r ? skid_val_r : eval;
  assign out_if.started  = skid_v_r ? skid_started_r : estarted;
  assign out_if.done_res = skid_v_r ? skid_done_r : edone;

endmodule
